>>> rtl/tmsl_pkg.sv
// Shared constants, codes and divider interface types for the tile map source locator.
`timescale 1ns / 1ps

package tmsl_pkg;

  // Tileset table and screen grid
  localparam int MaxTilesets = 8;
  localparam int SlotW       = $clog2(MaxTilesets);
  localparam int CountW      = 4;
  localparam int GridColumns = 64;
  localparam int GridRows    = 64;

  // Field widths
  localparam int IdW    = 16;
  localparam int ColsW  = 10;
  localparam int GridW  = 6;
  localparam int TsW    = 9;
  localparam int VelW   = 8;
  localparam int ScrollW = 32;
  localparam int RowW   = 17;
  localparam int ScolW  = 11;
  localparam int DestW  = 15;
  localparam int CfgW   = 9;

  // Shared divider
  localparam int DivW = 32;
  localparam int DvsW = 10;

  // Tile size limits and reset
  localparam logic [TsW-1:0] TsReset = TsW'(32);
  localparam logic [TsW-1:0] TsMax   = TsW'(256);

  // Operation codes
  localparam logic [1:0] OpTick = 2'd0;
  localparam logic [1:0] OpDraw = 2'd1;
  localparam logic [1:0] OpLoad = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgTileSize     = 2'd0;
  localparam logic [1:0] CfgVelocityX    = 2'd1;
  localparam logic [1:0] CfgVelocityY    = 2'd2;
  localparam logic [1:0] CfgTilesetCount = 2'd3;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DvsW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/tmsl_divider.sv
// Bit-serial restoring unsigned divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module tmsl_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmsl_pkg::div_req_t req_i,
  output tmsl_pkg::div_rsp_t rsp_o
);
  import tmsl_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] quo_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;

  logic [DvsW:0] shifted;
  logic [DvsW:0] diff;
  logic          ge;

  // Shift the next dividend bit into the partial remainder and trial-subtract
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DvsW-1:0] : shifted[DvsW-1:0];
        quo_q <= {quo_q[DivW-2:0], ge};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - CntW'(1);
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/tile_map_source_locator.sv
// Top level of the tile map source locator: tileset table, scroll state and draw sequencer.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_stall_o   operation, tile id, grid, tileset load
//   out      source     out_valid_o / out_stall_i draw flags, slot, source row/col, dest x/y
//   cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// Tick, load, unused codes and draws that are dropped early (empty id, no tileset,
// grid out of range) present their result in the cycle after their transfer. A full
// draw runs from its transfer to its result as a search of the table, one entry per
// step (1 to 8, one table read port), then three runs of the shared serial divider
// (id offset by column count, scroll x and scroll y by tile size), each a start
// state, 32 divider steps and the done pulse, then a load of the output register.
// A chosen set with no columns skips the first run. With no output stall the next
// transfer is taken in the cycle the result appears. Reset clears the scroll and the
// handshake state and sets the configuration to its reset values; the tileset table
// holds no reset value. Input is stalled while a draw is in flight or while a finished
// result is held by a stalled output.
`timescale 1ns / 1ps

module tile_map_source_locator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // configuration port
  input  logic                                    cfg_we_i,
  input  logic [1:0]                              cfg_index_i,
  input  logic [tmsl_pkg::CfgW-1:0]               cfg_data_i,
  // input channel
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [1:0]                              operation_i,
  input  logic [tmsl_pkg::IdW-1:0]                tile_id_i,
  input  logic [tmsl_pkg::GridW-1:0]              grid_column_i,
  input  logic [tmsl_pkg::GridW-1:0]              grid_row_i,
  input  logic [tmsl_pkg::SlotW-1:0]              set_slot_i,
  input  logic [tmsl_pkg::IdW-1:0]                set_first_id_i,
  input  logic [tmsl_pkg::ColsW-1:0]              set_columns_i,
  // output channel
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    draw_valid_o,
  output logic                                    no_tileset_o,
  output logic [tmsl_pkg::SlotW-1:0]              found_slot_o,
  output logic signed [tmsl_pkg::RowW-1:0]        source_row_o,
  output logic signed [tmsl_pkg::ScolW-1:0]       source_column_o,
  output logic signed [tmsl_pkg::DestW-1:0]       dest_x_o,
  output logic signed [tmsl_pkg::DestW-1:0]       dest_y_o
);
  import tmsl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_OFF,
    S_OFF_WAIT,
    S_SCX,
    S_SCX_WAIT,
    S_SCY,
    S_SCY_WAIT,
    S_FINISH
  } state_e;

  // Configuration registers
  logic [TsW-1:0]    tile_size_q;
  logic [VelW-1:0]   vel_x_q;
  logic [VelW-1:0]   vel_y_q;
  logic [CountW-1:0] count_q;

  // Tileset table: one write port for loads, one registered read port for the search
  logic [IdW-1:0]   first_mem [MaxTilesets];
  logic [ColsW-1:0] cols_mem  [MaxTilesets];
  logic [IdW-1:0]   rd_first_q;
  logic [ColsW-1:0] rd_cols_q;
  logic [SlotW-1:0] rd_addr;

  // Sequencer state
  state_e           state_q;
  logic [SlotW-1:0] idx_q;
  logic [IdW-1:0]   prev_first_q;
  logic [ColsW-1:0] prev_cols_q;
  logic [IdW-1:0]   id_q;
  logic [GridW-1:0] col_q;
  logic [GridW-1:0] row_q;
  logic [SlotW-1:0] sel_slot_q;
  logic [IdW-1:0]   sel_first_q;
  logic [ColsW-1:0] sel_cols_q;
  logic [RowW-1:0]  srow_q;
  logic [ScolW-1:0] scol_q;
  logic [DestW-1:0] dx_q;
  logic [ScrollW-1:0] scroll_x_q;
  logic [ScrollW-1:0] scroll_y_q;

  // Output register
  logic             out_valid_q;
  logic             draw_valid_q;
  logic             no_tileset_q;
  logic [SlotW-1:0] found_slot_q;
  logic [RowW-1:0]  source_row_q;
  logic [ScolW-1:0] source_column_q;
  logic [DestW-1:0] dest_x_q;
  logic [DestW-1:0] dest_y_q;

  // Shared divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_xfer;
  logic              out_free;
  logic              load_we;
  logic [TsW-1:0]    ts_eff;
  logic [CountW-1:0] count_eff;
  logic [CountW-1:0] count_m1;
  logic              last_entry;
  logic              hit_prev;
  logic [RowW-1:0]   off;
  logic              off_neg;
  logic [IdW-1:0]    off_mag;
  logic [ScrollW-1:0] scx_mag;
  logic [ScrollW-1:0] scy_mag;
  logic [DestW-1:0]  prod_x;
  logic [DestW-1:0]  prod_y;
  logic [DestW-1:0]  fine;
  logic [RowW-1:0]   quo_ext;
  logic [ScolW-1:0]  rem_ext;
  logic [ScrollW-1:0] vel_x_ext;
  logic [ScrollW-1:0] vel_y_ext;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_we    = in_xfer && (operation_i == OpLoad) && (int'(set_slot_i) < MaxTilesets);

  // Tile size: zero acts as one, above the limit acts as the limit
  always_comb begin
    if (tile_size_q == '0) begin
      ts_eff = TsW'(1);
    end else if (tile_size_q > TsMax) begin
      ts_eff = TsMax;
    end else begin
      ts_eff = tile_size_q;
    end
  end

  assign count_eff  = (int'(count_q) > MaxTilesets) ? CountW'(MaxTilesets) : count_q;
  assign count_m1   = count_eff - CountW'(1);
  assign last_entry = ({{(CountW-SlotW){1'b0}}, idx_q} == count_m1);
  assign hit_prev   = (idx_q != '0) && (id_q >= prev_first_q) && (id_q < rd_first_q);

  // Read address: entry zero when a draw starts, the next entry while searching
  assign rd_addr = (state_q == S_SEARCH) ? idx_q + SlotW'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      first_mem[set_slot_i] <= set_first_id_i;
      cols_mem[set_slot_i]  <= set_columns_i;
    end
    rd_first_q <= first_mem[rd_addr];
    rd_cols_q  <= cols_mem[rd_addr];
  end

  // Signed offset of the tile inside its set, split into sign and magnitude
  assign off     = {1'b0, id_q} - {1'b0, sel_first_q};
  assign off_neg = off[RowW-1];
  assign off_mag = off_neg ? IdW'(RowW'(0) - off) : off[IdW-1:0];

  // Scroll magnitudes for the C-style remainder
  assign scx_mag = scroll_x_q[ScrollW-1] ? ScrollW'(0) - scroll_x_q : scroll_x_q;
  assign scy_mag = scroll_y_q[ScrollW-1] ? ScrollW'(0) - scroll_y_q : scroll_y_q;

  assign prod_x = DestW'(col_q) * DestW'(ts_eff);
  assign prod_y = DestW'(row_q) * DestW'(ts_eff);

  // Fine scroll takes the sign of whichever scroll is being reduced
  always_comb begin
    logic neg;
    neg  = (state_q == S_SCX_WAIT) ? scroll_x_q[ScrollW-1] : scroll_y_q[ScrollW-1];
    fine = neg ? DestW'(0) - DestW'(div_rsp.remainder) : DestW'(div_rsp.remainder);
  end

  assign quo_ext = {1'b0, div_rsp.quotient[IdW-1:0]};
  assign rem_ext = {1'b0, div_rsp.remainder};

  assign vel_x_ext = {{(ScrollW-VelW){vel_x_q[VelW-1]}}, vel_x_q};
  assign vel_y_ext = {{(ScrollW-VelW){vel_y_q[VelW-1]}}, vel_y_q};

  // Divider requests come from the start states of the sequencer
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DivW'(off_mag);
    div_req.divisor  = sel_cols_q;
    case (state_q)
      S_OFF: begin
        div_req.start = (sel_cols_q != '0);
      end
      S_SCX: begin
        div_req.start    = 1'b1;
        div_req.dividend = scx_mag;
        div_req.divisor  = DvsW'(ts_eff);
      end
      S_SCY: begin
        div_req.start    = 1'b1;
        div_req.dividend = scy_mag;
        div_req.divisor  = DvsW'(ts_eff);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  tmsl_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= TsReset;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      count_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTileSize:     tile_size_q <= cfg_data_i[TsW-1:0];
        CfgVelocityX:    vel_x_q     <= cfg_data_i[VelW-1:0];
        CfgVelocityY:    vel_y_q     <= cfg_data_i[VelW-1:0];
        CfgTilesetCount: count_q     <= cfg_data_i[CountW-1:0];
        default:         count_q     <= count_q;
      endcase
    end
  end

  // Sequencer, scroll state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      idx_q           <= '0;
      prev_first_q    <= '0;
      prev_cols_q     <= '0;
      id_q            <= '0;
      col_q           <= '0;
      row_q           <= '0;
      sel_slot_q      <= '0;
      sel_first_q     <= '0;
      sel_cols_q      <= '0;
      srow_q          <= '0;
      scol_q          <= '0;
      dx_q            <= '0;
      scroll_x_q      <= '0;
      scroll_y_q      <= '0;
      out_valid_q     <= 1'b0;
      draw_valid_q    <= 1'b0;
      no_tileset_q    <= 1'b0;
      found_slot_q    <= '0;
      source_row_q    <= '0;
      source_column_q <= '0;
      dest_x_q        <= '0;
      dest_y_q        <= '0;
    end else begin
      // Drop the held result once the output side takes it
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            id_q  <= tile_id_i;
            col_q <= grid_column_i;
            row_q <= grid_row_i;
            // Default result: every field zero
            out_valid_q     <= 1'b1;
            draw_valid_q    <= 1'b0;
            no_tileset_q    <= 1'b0;
            found_slot_q    <= '0;
            source_row_q    <= '0;
            source_column_q <= '0;
            dest_x_q        <= '0;
            dest_y_q        <= '0;
            case (operation_i)
              OpTick: begin
                scroll_x_q <= scroll_x_q + vel_x_ext;
                scroll_y_q <= scroll_y_q + vel_y_ext;
              end
              OpDraw: begin
                if (tile_id_i == '0) begin
                  no_tileset_q <= 1'b0;
                end else if (count_eff == '0) begin
                  no_tileset_q <= 1'b1;
                end else if ((int'(grid_column_i) < GridColumns) &&
                             (int'(grid_row_i) < GridRows)) begin
                  // Hold the result back and start the ordered search at entry zero
                  out_valid_q <= 1'b0;
                  idx_q       <= '0;
                  state_q     <= S_SEARCH;
                end
              end
              default: begin
                no_tileset_q <= 1'b0;
              end
            endcase
          end
        end

        S_SEARCH: begin
          // rd_*_q holds entry idx_q; prev_*_q holds entry idx_q - 1
          if (hit_prev) begin
            sel_slot_q  <= idx_q - SlotW'(1);
            sel_first_q <= prev_first_q;
            sel_cols_q  <= prev_cols_q;
            state_q     <= S_OFF;
          end else if (last_entry) begin
            sel_slot_q  <= idx_q;
            sel_first_q <= rd_first_q;
            sel_cols_q  <= rd_cols_q;
            state_q     <= S_OFF;
          end else begin
            prev_first_q <= rd_first_q;
            prev_cols_q  <= rd_cols_q;
            idx_q        <= idx_q + SlotW'(1);
          end
        end

        S_OFF: begin
          // A set with no columns gives a zero source position
          if (sel_cols_q == '0) begin
            srow_q  <= '0;
            scol_q  <= '0;
            state_q <= S_SCX;
          end else begin
            state_q <= S_OFF_WAIT;
          end
        end

        S_OFF_WAIT: begin
          if (div_rsp.done) begin
            srow_q  <= off_neg ? RowW'(0) - quo_ext : quo_ext;
            scol_q  <= off_neg ? ScolW'(0) - rem_ext : rem_ext;
            state_q <= S_SCX;
          end
        end

        S_SCX: begin
          state_q <= S_SCX_WAIT;
        end

        S_SCX_WAIT: begin
          if (div_rsp.done) begin
            dx_q    <= prod_x - fine;
            state_q <= S_SCY;
          end
        end

        S_SCY: begin
          state_q <= S_SCY_WAIT;
        end

        S_SCY_WAIT: begin
          if (div_rsp.done) begin
            dest_y_q <= prod_y - fine;
            state_q  <= S_FINISH;
          end
        end

        S_FINISH: begin
          // Wait for the output register to free up, then present the draw
          if (out_free) begin
            out_valid_q     <= 1'b1;
            draw_valid_q    <= 1'b1;
            no_tileset_q    <= 1'b0;
            found_slot_q    <= sel_slot_q;
            source_row_q    <= srow_q;
            source_column_q <= scol_q;
            dest_x_q        <= dx_q;
            state_q         <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign draw_valid_o    = draw_valid_q;
  assign no_tileset_o    = no_tileset_q;
  assign found_slot_o    = found_slot_q;
  assign source_row_o    = source_row_q;
  assign source_column_o = source_column_q;
  assign dest_x_o        = dest_x_q;
  assign dest_y_o        = dest_y_q;

endmodule

>>> tb/tb_tile_map_source_locator.sv
// Self-checking testbench for the tile map source locator: directed and random transfers.
`timescale 1ns / 1ps

module tb_tile_map_source_locator;
  import tmsl_pkg::*;

  localparam time         ClkPeriod     = 20ns;
  localparam int          ResetCycles   = 12;
  localparam int          WatchdogLimit = 4000;
  localparam int          TailCycles    = 150;
  localparam int          SettleCycles  = 4;
  localparam int          MaxReports    = 10;
  localparam logic [1:0]  OpUnused      = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [IdW-1:0]   id;
    logic [GridW-1:0] col;
    logic [GridW-1:0] row;
    logic [SlotW-1:0] slot;
    logic [IdW-1:0]   first;
    logic [ColsW-1:0] ncols;
  } tile_item_t;

  typedef struct packed {
    logic             draw_valid;
    logic             no_tileset;
    logic [SlotW-1:0] slot;
    logic [RowW-1:0]  srow;
    logic [ScolW-1:0] scol;
    logic [DestW-1:0] dx;
    logic [DestW-1:0] dy;
  } locate_result_t;

  // Own copy of the locator state; one prediction per accepted transfer.
  class locator_scoreboard;
    locate_result_t   predicted_results[$];
    logic [TsW-1:0]     tile_size;
    logic [VelW-1:0]    vel_x;
    logic [VelW-1:0]    vel_y;
    logic [CountW-1:0]  set_count;
    logic [IdW-1:0]     first_ids[MaxTilesets];
    logic [ColsW-1:0]   col_counts[MaxTilesets];
    logic [ScrollW-1:0] scroll_x;
    logic [ScrollW-1:0] scroll_y;
    int                 errors;

    function new();
      tile_size = TsReset;
      vel_x     = '0;
      vel_y     = '0;
      set_count = '0;
      scroll_x  = '0;
      scroll_y  = '0;
      errors    = 0;
      foreach (first_ids[i]) begin
        first_ids[i]  = '0;
        col_counts[i] = '0;
      end
    endfunction

    function void write_register(logic [1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgTileSize:     tile_size = data[TsW-1:0];
        CfgVelocityX:    vel_x     = data[VelW-1:0];
        CfgVelocityY:    vel_y     = data[VelW-1:0];
        CfgTilesetCount: set_count = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function locate_result_t locate(tile_item_t it);
      locate_result_t r;
      int     cnt;
      int     s;
      int     ts;
      bit     hit;
      longint off;
      longint srow;
      longint scol;
      longint dx;
      longint dy;
      r = '0;
      case (it.op)
        OpTick: begin
          scroll_x = scroll_x + {{(ScrollW-VelW){vel_x[VelW-1]}}, vel_x};
          scroll_y = scroll_y + {{(ScrollW-VelW){vel_y[VelW-1]}}, vel_y};
        end
        OpLoad: begin
          if (it.slot < MaxTilesets) begin
            first_ids[it.slot]  = it.first;
            col_counts[it.slot] = it.ncols;
          end
        end
        OpDraw: begin
          cnt = (set_count > MaxTilesets) ? MaxTilesets : int'(set_count);
          if (it.id == '0) return r;
          if (cnt == 0) begin
            r.no_tileset = 1'b1;
            return r;
          end
          if (it.col >= GridColumns || it.row >= GridRows) return r;
          // first range that holds the id wins; the last entry catches the rest
          s   = cnt - 1;
          hit = 1'b0;
          for (int i = 0; i + 1 < cnt; i++) begin
            if (!hit && it.id >= first_ids[i] && it.id < first_ids[i+1]) begin
              s   = i;
              hit = 1'b1;
            end
          end
          off  = longint'(it.id) - longint'(first_ids[s]);
          srow = 0;
          scol = 0;
          if (col_counts[s] != '0) begin
            srow = off / longint'(col_counts[s]);
            scol = off % longint'(col_counts[s]);
          end
          ts = (tile_size == '0) ? 1 : (tile_size > TsMax) ? int'(TsMax) : int'(tile_size);
          // remainder follows the sign of the scroll
          dx = longint'(it.col) * ts - (longint'($signed(scroll_x)) % ts);
          dy = longint'(it.row) * ts - (longint'($signed(scroll_y)) % ts);
          r.draw_valid = 1'b1;
          r.slot       = s[SlotW-1:0];
          r.srow       = srow[RowW-1:0];
          r.scol       = scol[ScolW-1:0];
          r.dx         = dx[DestW-1:0];
          r.dy         = dy[DestW-1:0];
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(tile_item_t it);
      predicted_results.push_back(locate(it));
    endfunction

    function void check_result(locate_result_t got);
      locate_result_t exp;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result with nothing expected: dv=%0b nt=%0b", $realtime,
                   got.draw_valid, got.no_tileset);
        return;
      end
      exp = predicted_results.pop_front();
      if (got.draw_valid !== exp.draw_valid || got.no_tileset !== exp.no_tileset ||
          got.slot !== exp.slot || got.srow !== exp.srow || got.scol !== exp.scol ||
          got.dx !== exp.dx || got.dy !== exp.dy) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: mismatch, expected dv=%0b nt=%0b slot=%0d row=%0d col=%0d x=%0d y=%0d",
                   $realtime, exp.draw_valid, exp.no_tileset, exp.slot, $signed(exp.srow),
                   $signed(exp.scol), $signed(exp.dx), $signed(exp.dy));
          $display("%0t:           actual dv=%0b nt=%0b slot=%0d row=%0d col=%0d x=%0d y=%0d",
                   $realtime, got.draw_valid, got.no_tileset, got.slot, $signed(got.srow),
                   $signed(got.scol), $signed(got.dx), $signed(got.dy));
        end
      end
    endfunction

    function int pending();
      return predicted_results.size();
    endfunction
  endclass

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    cfg_we      = 1'b0;
  logic [1:0]              cfg_index   = '0;
  logic [CfgW-1:0]         cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [1:0]              operation   = '0;
  logic [IdW-1:0]          tile_id     = '0;
  logic [GridW-1:0]        grid_column = '0;
  logic [GridW-1:0]        grid_row    = '0;
  logic [SlotW-1:0]        set_slot    = '0;
  logic [IdW-1:0]          set_first   = '0;
  logic [ColsW-1:0]        set_columns = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic                    draw_valid;
  logic                    no_tileset;
  logic [SlotW-1:0]        found_slot;
  logic signed [RowW-1:0]  source_row;
  logic signed [ScolW-1:0] source_column;
  logic signed [DestW-1:0] dest_x;
  logic signed [DestW-1:0] dest_y;

  locator_scoreboard sb = new();

  int             tx_idle_pct = 0;
  int             rx_idle_pct = 0;
  int             idle_cycles = 0;
  logic [IdW-1:0] table_first[MaxTilesets];  // first ids as last loaded, to aim draws

  tile_map_source_locator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .operation_i     (operation),
    .tile_id_i       (tile_id),
    .grid_column_i   (grid_column),
    .grid_row_i      (grid_row),
    .set_slot_i      (set_slot),
    .set_first_id_i  (set_first),
    .set_columns_i   (set_columns),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .draw_valid_o    (draw_valid),
    .no_tileset_o    (no_tileset),
    .found_slot_o    (found_slot),
    .source_row_o    (source_row),
    .source_column_o (source_column),
    .dest_x_o        (dest_x),
    .dest_y_o        (dest_y)
  );

  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Sample both channels at the edge. Note the input first; a result always leaves
  // after its transfer, so its prediction is already queued when it is checked.
  always @(posedge clk) begin
    locate_result_t got;
    tile_item_t     it;
    if (in_valid && !in_stall) begin
      it = '{op: operation, id: tile_id, col: grid_column, row: grid_row,
             slot: set_slot, first: set_first, ncols: set_columns};
      sb.note_input(it);
    end
    if (out_valid && !out_stall) begin
      got = '{draw_valid: draw_valid, no_tileset: no_tileset, slot: found_slot,
              srow: source_row, scol: source_column, dx: dest_x, dy: dest_y};
      sb.check_result(got);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: end the run when no transfer has happened for too long.
  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk);
    $display("tile_map_source_locator test failed");
    $finish;
  end

  // Write one register; hold the enable for a single edge, then drop it.
  task automatic write_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_register(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Present one item and hold it until the transfer; leave valid high behind it.
  task automatic send_item(input tile_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= it.op;
    tile_id     <= it.id;
    grid_column <= it.col;
    grid_row    <= it.row;
    set_slot    <= it.slot;
    set_first   <= it.first;
    set_columns <= it.ncols;
    if (it.op == OpLoad) table_first[it.slot] = it.first;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has left the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic tile_item_t item(logic [1:0] op, int id, int col, int row,
                                      int slot, int first, int ncols);
    tile_item_t it;
    it = '{op: op, id: id[IdW-1:0], col: col[GridW-1:0], row: row[GridW-1:0],
           slot: slot[SlotW-1:0], first: first[IdW-1:0], ncols: ncols[ColsW-1:0]};
    return it;
  endfunction

  // Load all entries with ascending first ids and random widths.
  task automatic load_sorted_table();
    int first;
    int ncols;
    first = $urandom_range(1, 400);
    for (int i = 0; i < MaxTilesets; i++) begin
      ncols = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 1023);
      send_item(item(OpLoad, $urandom, $urandom, $urandom, i, first, ncols));
      if ($urandom_range(0, 15) != 0) first = first + $urandom_range(1, 8000);
      if (first > 65535) first = 65535;
    end
  endtask

  function automatic tile_item_t random_item();
    tile_item_t it;
    int         pick;
    int         id;
    int         k;
    it   = item(OpDraw, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it.op = OpTick;
    end else if (pick < 25) begin
      // noise load: any slot, any content, sorting not kept
      it.op = OpLoad;
      if ($urandom_range(0, 9) == 0) it.ncols = '0;
    end else if (pick < 30) begin
      it.op = OpUnused;
    end else begin
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, MaxTilesets - 1);
      if (pick < 8) id = 0;
      else if (pick < 23) id = $urandom_range(1, 65535);
      else if (pick < 33) id = int'(table_first[k]) - 1;
      else id = int'(table_first[k]) + $urandom_range(0, 2000);
      if (id > 65535) id = 65535;
      if (id < 0) id = 0;
      it.id = id[IdW-1:0];
    end
    return it;
  endfunction

  task automatic randomise_config(input bit all_regs);
    int pick;
    if (all_regs || $urandom_range(0, 1)) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(CfgTileSize, '0);
      else if (pick == 1) write_reg(CfgTileSize, CfgW'($urandom_range(256, 511)));
      else if (pick == 2) write_reg(CfgTileSize, CfgW'($urandom_range(65, 255)));
      else write_reg(CfgTileSize, CfgW'($urandom_range(1, 64)));
    end
    if (all_regs || $urandom_range(0, 1)) write_reg(CfgVelocityX, CfgW'($urandom));
    if (all_regs || $urandom_range(0, 1)) write_reg(CfgVelocityY, CfgW'($urandom));
    if (all_regs || $urandom_range(0, 1)) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(CfgTilesetCount, '0);
      else if (pick < 3) write_reg(CfgTilesetCount, CfgW'($urandom_range(9, 15)));
      else write_reg(CfgTilesetCount, CfgW'($urandom_range(1, MaxTilesets)));
    end
  endtask

  initial begin
    automatic int firsts[MaxTilesets] = '{1, 100, 200, 1000, 5000, 20000, 40000, 65535};
    automatic int widths[MaxTilesets] = '{1, 1023, 0, 7, 16, 3, 1023, 512};
    foreach (table_first[i]) table_first[i] = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration, no entries in use: draws report a missing tileset,
    // the empty id gives nothing, ticks and the unused code give empty results.
    send_item(item(OpDraw, 5, 3, 4, 0, 0, 0));
    send_item(item(OpDraw, 0, 0, 0, 0, 0, 0));
    send_item(item(OpDraw, 65535, 63, 63, 7, 65535, 1023));
    send_item(item(OpTick, 0, 0, 0, 0, 0, 0));
    send_item(item(OpUnused, 65535, 63, 63, 7, 65535, 1023));
    // Fill every entry before any draw can search the table.
    for (int i = 0; i < MaxTilesets; i++)
      send_item(item(OpLoad, 0, 0, 0, i, firsts[i], widths[i]));
    wait_drained();

    // Extreme scroll speeds and largest tile size, full table.
    write_reg(CfgTileSize, 9'd256);
    write_reg(CfgVelocityX, 9'h080);
    write_reg(CfgVelocityY, 9'd127);
    write_reg(CfgTilesetCount, 9'd8);
    send_item(item(OpTick, 0, 0, 0, 0, 0, 0));
    send_item(item(OpTick, 0, 0, 0, 0, 0, 0));
    send_item(item(OpDraw, 1, 0, 0, 0, 0, 0));        // first id of the first set
    send_item(item(OpDraw, 99, 63, 63, 0, 0, 0));     // last id of the first set
    send_item(item(OpDraw, 100, 1, 2, 0, 0, 0));      // start of the second set
    send_item(item(OpDraw, 250, 5, 6, 0, 0, 0));      // set with zero columns
    send_item(item(OpDraw, 1006, 7, 8, 0, 0, 0));
    send_item(item(OpDraw, 65535, 9, 10, 0, 0, 0));   // last set catches the top id
    send_item(item(OpDraw, 64000, 11, 12, 0, 0, 0));
    send_item(item(OpDraw, 0, 13, 14, 0, 0, 0));
    wait_drained();

    // Tile size of zero acts as one; a count beyond the table acts as full.
    write_reg(CfgTileSize, '0);
    write_reg(CfgTilesetCount, 9'd15);
    send_item(item(OpDraw, 45000, 20, 30, 0, 0, 0));
    wait_drained();

    // Oversized tile, a single entry catching every id.
    write_reg(CfgTileSize, 9'd511);
    write_reg(CfgTilesetCount, 9'd1);
    write_reg(CfgVelocityX, 9'd127);
    send_item(item(OpTick, 0, 0, 0, 0, 0, 0));
    send_item(item(OpDraw, 300, 40, 50, 0, 0, 0));

    // Random part: three idling phases, each split into stretches separated by
    // a full drain, so the sender regularly pauses until nothing is expected.
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 46 : 0;
      rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 18 : 0;
      for (int stretch = 0; stretch < 8; stretch++) begin
        wait_drained();
        randomise_config(stretch == 0);
        if ($urandom_range(0, 2) == 0) load_sorted_table();
        repeat (40) send_item(random_item());
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tile_map_source_locator test passed");
    end else begin
      $display("tile_map_source_locator test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tmsl_pkg.sv
rtl/tmsl_divider.sv
rtl/tile_map_source_locator.sv
tb/tb_tile_map_source_locator.sv
